[hdl/ogru_pkg.sv]
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared types, codes and the quarter-wave sine table of the occupancy grid
// ray update block.
// ----------------------------------------------------------------------------
package ogru_pkg;

    // default geometry
    localparam int MAP_COLS_DEF   = 256;
    localparam int MAP_ROWS_DEF   = 256;
    localparam int ANGLE_BITS_DEF = 12;

    // quarter-wave table size
    localparam int QBITS = 10;
    localparam int QSIZE = 1 << QBITS;

    // operation codes
    typedef enum logic [1:0] {
        OP_BEAM = 2'd0,
        OP_FOOT = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // cell codes
    localparam logic [1:0] CELL_UNDEF = 2'd0;
    localparam logic [1:0] CELL_EMPTY = 2'd1;
    localparam logic [1:0] CELL_OCC   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_COLS_USED = 3'd2;
    localparam logic [2:0] REG_ROWS_USED = 3'd3;
    localparam logic [2:0] REG_CELL_SHIFT = 3'd4;
    localparam logic [2:0] REG_STEP_LEN  = 3'd5;
    localparam logic [2:0] REG_FOOT_HALF = 3'd6;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SIN,
        ST_COS,
        ST_TRIG,
        ST_NEXT,
        ST_WAIT,
        ST_RMW,
        ST_RDCELL,
        ST_DONE
    } state_t;

    // grid placement seen by the point locator
    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [8:0]         cols_eff;
        logic [8:0]         rows_eff;
        logic [3:0]         cell_shift;
    } grid_cfg_t;

    // one point request: base + trig * reach / 2^14 on each axis
    typedef struct packed {
        logic               start;
        logic signed [17:0] base_x;
        logic signed [17:0] base_y;
        logic signed [15:0] trig_c;
        logic signed [15:0] trig_s;
        logic [16:0]        reach;
    } loc_req_t;

    typedef logic [14:0] qrom_t [0:QSIZE];

    // sin(i * pi / 2048) in Q2.14 by an eight-term integer Taylor series
    function automatic qrom_t build_qrom();
        qrom_t       t;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] tm;
        logic [63:0] q;
        for (int i = 0; i <= QSIZE; i++) begin
            x  = (64'd1686629713 * 64'(i)) >> QBITS;
            s  = x;
            tm = x;
            for (int k = 1; k <= 7; k++) begin
                tm = (tm * x) >> 30;
                tm = (tm * x) >> 30;
                unique case (k)
                    1:       tm = tm / 64'd6;
                    2:       tm = tm / 64'd20;
                    3:       tm = tm / 64'd42;
                    4:       tm = tm / 64'd72;
                    5:       tm = tm / 64'd110;
                    6:       tm = tm / 64'd156;
                    default: tm = tm / 64'd210;
                endcase
                if (k % 2 == 1)
                    s = s - tm;
                else
                    s = s + tm;
            end
            q = (s + 64'd32768) >> 16;
            if (q > 64'd16384)
                q = 64'd16384;
            t[i] = 15'(q);
        end
        return t;
    endfunction

    localparam qrom_t QUARTER_ROM = build_qrom();

endpackage

[hdl/ogru_sin_rom.sv]
// ----------------------------------------------------------------------------
// ogru_sin_rom
// Sine lookup from a 16-bit phase through the quarter-wave table, registered.
// ----------------------------------------------------------------------------
module ogru_sin_rom
(
    input  logic               clk,
    input  logic [15:0]        phase16,
    output logic signed [15:0] sin_val
);
    import ogru_pkg::*;

    logic [QBITS:0] idx;
    logic [14:0]    mag_reg;
    logic           neg_reg;

    // odd quadrants run the table backwards
    always_comb
    begin
        if (phase16[14])
            idx = (QBITS+1)'(QSIZE) - {1'b0, phase16[13:14-QBITS]};
        else
            idx = {1'b0, phase16[13:14-QBITS]};
    end

    // registered table read
    always_ff @(posedge clk)
    begin
        mag_reg <= QUARTER_ROM[idx];
        neg_reg <= phase16[15];
    end

    // lower half-turn is negative
    assign sin_val = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

[hdl/ogru_locate.sv]
// ----------------------------------------------------------------------------
// ogru_locate
// Three-stage point locator: project, offset by origin, scale to a cell and
// check against the grid bounds.
// ----------------------------------------------------------------------------
module ogru_locate #(
    parameter int MAP_COLS = ogru_pkg::MAP_COLS_DEF,
    parameter int ADDR_W   = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ogru_pkg::grid_cfg_t cfg,
    input  ogru_pkg::loc_req_t  req,
    output logic                done,
    output logic                in_bounds,
    output logic [ADDR_W-1:0]   addr
);
    import ogru_pkg::*;

    logic               v1_reg;
    logic               v2_reg;
    logic               done_reg;
    logic signed [33:0] prod_x_reg;
    logic signed [33:0] prod_y_reg;
    logic signed [17:0] base_x_reg;
    logic signed [17:0] base_y_reg;
    logic signed [20:0] diff_x_reg;
    logic signed [20:0] diff_y_reg;
    logic               inside_reg;
    logic [ADDR_W-1:0]  addr_reg;

    logic signed [33:0] qx_full;
    logic signed [33:0] qy_full;
    logic signed [20:0] diff_x_next;
    logic signed [20:0] diff_y_next;
    logic [20:0]        round_mask;
    logic signed [20:0] ix;
    logic signed [20:0] iy;
    logic               inside_next;
    logic [ADDR_W-1:0]  addr_next;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // stage 1: products
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            prod_x_reg <= 34'(req.trig_c * $signed({1'b0, req.reach}));
            prod_y_reg <= 34'(req.trig_s * $signed({1'b0, req.reach}));
            base_x_reg <= req.base_x;
            base_y_reg <= req.base_y;
        end
    end

    // stage 2: divide by 2^14 toward zero, add base, remove origin
    always_comb
    begin
        qx_full     = (prod_x_reg + (prod_x_reg[33] ? 34'sd16383 : 34'sd0)) >>> 14;
        qy_full     = (prod_y_reg + (prod_y_reg[33] ? 34'sd16383 : 34'sd0)) >>> 14;
        diff_x_next = 21'(base_x_reg) + 21'(qx_full) - 21'(cfg.origin_x);
        diff_y_next = 21'(base_y_reg) + 21'(qy_full) - 21'(cfg.origin_y);
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            diff_x_reg <= diff_x_next;
            diff_y_reg <= diff_y_next;
        end
    end

    // stage 3: cell index toward zero, bounds, address
    always_comb
    begin
        round_mask  = ~(21'h1FFFFF << cfg.cell_shift);
        ix = (diff_x_reg + (diff_x_reg[20] ? $signed(round_mask) : 21'sd0)) >>> cfg.cell_shift;
        iy = (diff_y_reg + (diff_y_reg[20] ? $signed(round_mask) : 21'sd0)) >>> cfg.cell_shift;
        inside_next = !ix[20] && (ix < $signed({12'b0, cfg.cols_eff}))
                   && !iy[20] && (iy < $signed({12'b0, cfg.rows_eff}));
        addr_next   = ADDR_W'(iy[8:0]) * ADDR_W'(MAP_COLS) + ADDR_W'(ix[8:0]);
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            inside_reg <= inside_next;
            addr_reg   <= addr_next;
        end
    end

    assign done      = done_reg;
    assign in_bounds = inside_reg;
    assign addr      = addr_reg;

endmodule

[hdl/ogru_cell_mem.sv]
// ----------------------------------------------------------------------------
// ogru_cell_mem
// Single-port cell store, two bits per cell, registered read.
// ----------------------------------------------------------------------------
module ogru_cell_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [1:0]        wdata,
    output logic [1:0]        rdata
);
    logic [1:0] mem [0:DEPTH-1];
    logic [1:0] rdata_reg;

    // read-first port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/occupancy_grid_ray_update.sv]
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// Occupancy grid kept in one cell memory, updated by beam and footprint words
// and read back by read words.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  input    | in_valid/in_ready, op, pos_x, pos_y,      | in
//           | heading, beam_angle, range, cell_col/row  |
//  result   | out_valid/out_ready, cell_state, in_grid  | out
//  config   | cfg_wr_en, cfg_addr, cfg_wr_data          | in
//
//  Beam: sine and cosine lookup, then per empty step issue, locator pipeline
//  of 3 and memory read-modify-write; a step that leaves the grid and the
//  hit cell skip the read-modify-write. Footprint: the same per point of the
//  square, the write only for points inside. The locator takes one point at
//  a time. After reset a clearing pass writes every cell undefined; no word
//  is accepted meanwhile, configuration writes are. A new word is accepted
//  while the previous result waits in the output register; a finished result
//  stalls until that register is free.
// ----------------------------------------------------------------------------
module occupancy_grid_ray_update #(
    parameter int MAP_COLS   = ogru_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS   = ogru_pkg::MAP_ROWS_DEF,
    parameter int ANGLE_BITS = ogru_pkg::ANGLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [11:0] heading,
    input  logic [11:0] beam_angle,
    input  logic [15:0] range,
    input  logic [7:0]  cell_col,
    input  logic [7:0]  cell_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  cell_state,
    output logic        in_grid,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data
);
    import ogru_pkg::*;

    localparam int DEPTH  = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);

    state_t state_reg;
    state_t state_next;

    // configuration
    logic signed [15:0] origin_x_reg;
    logic signed [15:0] origin_y_reg;
    logic [8:0]         cols_used_reg;
    logic [8:0]         rows_used_reg;
    logic [3:0]         cell_shift_reg;
    logic [7:0]         step_len_reg;
    logic [7:0]         foot_half_reg;

    // word in flight
    op_t                op_reg;
    logic signed [15:0] px_reg;
    logic signed [15:0] py_reg;
    logic [ANGLE_BITS-1:0] phase_reg;
    logic [15:0]        range_reg;
    logic [16:0]        d_reg;
    logic signed [17:0] x_reg;
    logic signed [17:0] y_reg;
    logic signed [17:0] y0_reg;
    logic signed [17:0] xlim_reg;
    logic signed [17:0] ylim_reg;
    logic               brk_reg;
    logic               hit_reg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;
    logic [1:0]         res_state_reg;
    logic               res_in_reg;

    // output register and clearing sweep
    logic               out_valid_reg;
    logic [1:0]         cell_state_reg;
    logic               in_grid_reg;
    logic [ADDR_W-1:0]  clr_reg;

    logic [7:0]         step;
    grid_cfg_t          gcfg;
    loc_req_t           loc_req;
    logic               loc_done;
    logic               loc_inside;
    logic [ADDR_W-1:0]  loc_addr;
    logic [ANGLE_BITS-1:0] rom_phase;
    logic [15:0]        phase16;
    logic signed [15:0] sin_val;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [1:0]         mem_wdata;
    logic [1:0]         mem_rdata;
    logic               rd_in;
    logic [ADDR_W-1:0]  rd_addr;
    logic               beam_more;
    logic               fp_x_in;
    logic               fp_y_in;
    logic               out_free;

    // effective grid size and step
    always_comb
    begin
        step          = (step_len_reg == 8'd0) ? 8'd1 : step_len_reg;
        gcfg.origin_x = origin_x_reg;
        gcfg.origin_y = origin_y_reg;
        gcfg.cols_eff = (int'(cols_used_reg) > MAP_COLS) ? 9'(MAP_COLS) : cols_used_reg;
        gcfg.rows_eff = (int'(rows_used_reg) > MAP_ROWS) ? 9'(MAP_ROWS) : rows_used_reg;
        gcfg.cell_shift = cell_shift_reg;
        rd_in   = ({1'b0, cell_col} < gcfg.cols_eff) && ({1'b0, cell_row} < gcfg.rows_eff);
        rd_addr = ADDR_W'(cell_row) * ADDR_W'(MAP_COLS) + ADDR_W'(cell_col);
        beam_more = !brk_reg && (d_reg < {1'b0, range_reg});
        fp_x_in   = x_reg < xlim_reg;
        fp_y_in   = y_reg < ylim_reg;
        out_free  = !out_valid_reg || out_ready;
    end

    // sine then cosine phase for the table
    always_comb
    begin
        if (state_reg == ST_SIN)
            rom_phase = phase_reg;
        else
            rom_phase = phase_reg + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
        phase16 = 16'(32'(rom_phase) << (16 - ANGLE_BITS));
    end

    ogru_sin_rom u_sin (
        .clk     (clk),
        .phase16 (phase16),
        .sin_val (sin_val)
    );

    // point request
    always_comb
    begin
        loc_req.trig_c = cos_reg;
        loc_req.trig_s = sin_reg;
        if (op_reg == OP_BEAM)
        begin
            loc_req.start  = (state_reg == ST_NEXT);
            loc_req.base_x = 18'(px_reg);
            loc_req.base_y = 18'(py_reg);
            loc_req.reach  = beam_more ? d_reg : {1'b0, range_reg};
        end
        else
        begin
            loc_req.start  = (state_reg == ST_NEXT) && fp_x_in && fp_y_in;
            loc_req.base_x = x_reg;
            loc_req.base_y = y_reg;
            loc_req.reach  = 17'd0;
        end
    end

    ogru_locate #(
        .MAP_COLS (MAP_COLS),
        .ADDR_W   (ADDR_W)
    ) u_locate (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (gcfg),
        .req       (loc_req),
        .done      (loc_done),
        .in_bounds (loc_inside),
        .addr      (loc_addr)
    );

    ogru_cell_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_reg == ADDR_W'(DEPTH - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_valid)
                begin
                    unique case (op_t'(op))
                        OP_BEAM: state_next = ST_SIN;
                        OP_FOOT: state_next = ST_NEXT;
                        OP_READ: state_next = rd_in ? ST_RDCELL : ST_DONE;
                        default: state_next = ST_DONE;
                    endcase
                end
            ST_SIN:  state_next = ST_COS;
            ST_COS:  state_next = ST_TRIG;
            ST_TRIG: state_next = ST_NEXT;
            ST_NEXT:
                if (op_reg == OP_BEAM || (fp_x_in && fp_y_in))
                    state_next = ST_WAIT;
                else if (!fp_x_in)
                    state_next = ST_DONE;
            ST_WAIT:
                if (loc_done)
                begin
                    priority if (hit_reg)
                        state_next = ST_DONE;
                    else if (loc_inside)
                        state_next = ST_RMW;
                    else
                        state_next = ST_NEXT;
                end
            ST_RMW:    state_next = ST_NEXT;
            ST_RDCELL: state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        mem_we    = 1'b0;
        mem_addr  = loc_addr;
        mem_wdata = CELL_EMPTY;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = CELL_UNDEF;
            end
            ST_IDLE:
                mem_addr = rd_addr;
            ST_WAIT:
                if (loc_done && hit_reg && loc_inside)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = CELL_OCC;
                end
            ST_RMW:
                mem_we = (mem_rdata != CELL_OCC);
            default:
                mem_we = 1'b0;
        endcase
    end

    // state register and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            cols_used_reg  <= 9'd256;
            rows_used_reg  <= 9'd256;
            cell_shift_reg <= 4'd4;
            step_len_reg   <= 8'd8;
            foot_half_reg  <= 8'd64;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_ORIGIN_X:   origin_x_reg   <= cfg_wr_data;
                REG_ORIGIN_Y:   origin_y_reg   <= cfg_wr_data;
                REG_COLS_USED:  cols_used_reg  <= cfg_wr_data[8:0];
                REG_ROWS_USED:  rows_used_reg  <= cfg_wr_data[8:0];
                REG_CELL_SHIFT: cell_shift_reg <= cfg_wr_data[3:0];
                REG_STEP_LEN:   step_len_reg   <= cfg_wr_data[7:0];
                REG_FOOT_HALF:  foot_half_reg  <= cfg_wr_data[7:0];
                default:        ;
            endcase
        end
    end

    // word datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    op_reg        <= op_t'(op);
                    px_reg        <= pos_x;
                    py_reg        <= pos_y;
                    phase_reg     <= ANGLE_BITS'(heading) + ANGLE_BITS'(beam_angle);
                    range_reg     <= range;
                    d_reg         <= {9'd0, step};
                    brk_reg       <= 1'b0;
                    hit_reg       <= 1'b0;
                    x_reg         <= 18'(pos_x) - 18'(foot_half_reg);
                    y_reg         <= 18'(pos_y) - 18'(foot_half_reg);
                    y0_reg        <= 18'(pos_y) - 18'(foot_half_reg);
                    xlim_reg      <= 18'(pos_x) + 18'(foot_half_reg);
                    ylim_reg      <= 18'(pos_y) + 18'(foot_half_reg);
                    res_state_reg <= CELL_UNDEF;
                    res_in_reg    <= 1'b0;
                end
            ST_COS:
                sin_reg <= sin_val;
            ST_TRIG:
                cos_reg <= sin_val;
            ST_NEXT:
                if (op_reg == OP_BEAM)
                    hit_reg <= !beam_more;
                else if (fp_x_in && !fp_y_in)
                begin
                    y_reg <= y0_reg;
                    x_reg <= x_reg + 18'(step);
                end
            ST_WAIT:
                if (loc_done)
                begin
                    priority if (hit_reg)
                    begin
                        res_in_reg    <= loc_inside;
                        res_state_reg <= loc_inside ? CELL_OCC : CELL_UNDEF;
                    end
                    else if (!loc_inside)
                    begin
                        if (op_reg == OP_BEAM)
                            brk_reg <= 1'b1;
                        else
                            y_reg <= y_reg + 18'(step);
                    end
                end
            ST_RMW:
                if (op_reg == OP_BEAM)
                    d_reg <= d_reg + 17'(step);
                else
                    y_reg <= y_reg + 18'(step);
            ST_RDCELL:
            begin
                res_state_reg <= mem_rdata;
                res_in_reg    <= 1'b1;
            end
            default:
                ;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            cell_state_reg <= res_state_reg;
            in_grid_reg    <= res_in_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_state = cell_state_reg;
    assign in_grid    = in_grid_reg;

`ifndef SYNTHESIS
    // the sweep only writes undefined cells
    a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (mem_we && mem_wdata == CELL_UNDEF))
        else $error("clearing pass did not write an undefined cell");

    // an occupied cell is never overwritten by an empty mark
    a_keep_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW && mem_rdata == CELL_OCC) |-> !mem_we)
        else $error("occupied cell overwritten");

    // a result outside the grid carries an undefined state
    a_outside_undef: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !in_grid) |-> (cell_state == CELL_UNDEF))
        else $error("outside result with a defined state");

    // an accepted word always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted word did not start");

    // no point request while one is in the locator
    a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT && !loc_done) |-> !loc_req.start)
        else $error("point request overlapped");
`endif

endmodule

[tb/tb_occupancy_grid_ray_update.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_ray_update
// Drives beam, footprint, read and unused words through the grid update
// block under several grid placements, predicts every result with a
// software copy of the grid and checks each result word as it leaves.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_ray_update;
    import ogru_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;

    typedef struct {
        logic [1:0] state;
        logic       in_bounds;
    } cell_result_t;

    // ------------------------------------------------------------------
    // grid predictor and result scoreboard
    // ------------------------------------------------------------------
    class grid_scoreboard;
        logic [1:0]   grid [65536];
        int           qrom [QSIZE + 1];
        int           org_x, org_y, cols, rows, shift, step, half;
        cell_result_t pending [$];
        int           errors, n_words, n_results;

        function new();
            longint unsigned x, s, tm, q;
            for (int i = 0; i <= QSIZE; i++) begin
                x  = (64'd1686629713 * i) >> QBITS;
                s  = x;
                tm = x;
                for (int k = 1; k <= 7; k++) begin
                    tm = (tm * x) >> 30;
                    tm = (tm * x) >> 30;
                    tm = tm / ((2 * k) * (2 * k + 1));
                    if (k % 2 == 1) s = s - tm;
                    else            s = s + tm;
                end
                q = (s + 64'd32768) >> 16;
                if (q > 64'd16384) q = 64'd16384;
                qrom[i] = int'(q);
            end
            foreach (grid[i]) grid[i] = CELL_UNDEF;
            org_x = 0; org_y = 0; cols = 256; rows = 256;
            shift = 4; step = 8; half = 64;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                REG_ORIGIN_X:   org_x = int'(signed'(val));
                REG_ORIGIN_Y:   org_y = int'(signed'(val));
                REG_COLS_USED:  cols  = int'(val[8:0]);
                REG_ROWS_USED:  rows  = int'(val[8:0]);
                REG_CELL_SHIFT: shift = int'(val[3:0]);
                REG_STEP_LEN:   step  = int'(val[7:0]);
                REG_FOOT_HALF:  half  = int'(val[7:0]);
                default: ;
            endcase
        endfunction

        function int sine(int phase);
            int p16, quad, r, mag;
            p16  = (phase << 4) & 16'hFFFF;
            quad = p16 >> 14;
            r    = (p16 & 16'h3FFF) >> 4;
            mag  = quad[0] ? qrom[QSIZE - r] : qrom[r];
            return quad[1] ? -mag : mag;
        endfunction

        function longint project(int base, int trig, int reach);
            return longint'(base) + (longint'(trig) * reach) / 16384;
        endfunction

        // truncating index toward zero, then bounds against used size
        function bit mark(longint cx, longint cy, logic [1:0] val, output int addr);
            longint ix, iy, div;
            div  = longint'(1) << shift;
            ix   = (cx - org_x) / div;
            iy   = (cy - org_y) / div;
            addr = 0;
            if (ix < 0 || ix >= (cols > 256 ? 256 : cols) ||
                iy < 0 || iy >= (rows > 256 ? 256 : rows))
                return 0;
            addr = int'(iy) * 256 + int'(ix);
            if (grid[addr] != CELL_OCC) grid[addr] = val;
            return 1;
        endfunction

        function void note_word(op_t op, int px, int py, int hd, int ba, int rng,
                                int col, int row);
            cell_result_t r;
            int st, ph, s, c, a;
            r.state     = CELL_UNDEF;
            r.in_bounds = 0;
            st = (step == 0) ? 1 : step;
            case (op)
                OP_BEAM: begin
                    ph = (hd + ba) & 12'hFFF;
                    s  = sine(ph);
                    c  = sine((ph + 1024) & 12'hFFF);
                    for (int d = st; d < rng; d += st)
                        if (!mark(project(px, c, d), project(py, s, d), CELL_EMPTY, a))
                            break;
                    if (mark(project(px, c, rng), project(py, s, rng), CELL_OCC, a)) begin
                        r.in_bounds = 1;
                        r.state     = grid[a];
                    end
                end
                OP_FOOT: begin
                    for (int x = px - half; x < px + half; x += st)
                        for (int y = py - half; y < py + half; y += st)
                            void'(mark(x, y, CELL_EMPTY, a));
                end
                OP_READ: begin
                    if (col < (cols > 256 ? 256 : cols) && row < (rows > 256 ? 256 : rows)) begin
                        r.in_bounds = 1;
                        r.state     = grid[row * 256 + col];
                    end
                end
                default: ;
            endcase
            pending.push_back(r);
            n_words++;
        endfunction

        function void check_result(logic [1:0] state, logic in_bounds);
            cell_result_t e;
            n_results++;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: cell_state %0d in_grid %0d",
                       state, in_bounds);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (state !== e.state) begin
                $error("cell_state: expected %0d, got %0d", e.state, state);
                errors++;
            end
            if (in_bounds !== e.in_bounds) begin
                $error("in_grid: expected %0d, got %0d", e.in_bounds, in_bounds);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // signals and instance
    // ------------------------------------------------------------------
    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [1:0]         op = OP_NONE;
    logic signed [15:0] pos_x = 0;
    logic signed [15:0] pos_y = 0;
    logic [11:0]        heading = 0;
    logic [11:0]        beam_angle = 0;
    logic [15:0]        range = 0;
    logic [7:0]         cell_col = 0;
    logic [7:0]         cell_row = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [1:0]         cell_state;
    logic               in_grid;
    logic               cfg_wr_en = 0;
    logic [2:0]         cfg_addr = REG_ORIGIN_X;
    logic [15:0]        cfg_wr_data = 0;

    grid_scoreboard sb = new();
    bit no_idle = 0;
    bit hold_req = 0;
    int quiet_cycles = 0;

    occupancy_grid_ray_update dut (
        .clk, .rst_n, .in_valid, .in_ready, .op, .pos_x, .pos_y, .heading,
        .beam_angle, .range, .cell_col, .cell_row, .out_valid, .out_ready,
        .cell_state, .in_grid, .cfg_wr_en, .cfg_addr, .cfg_wr_data
    );

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // ------------------------------------------------------------------
    // monitors: accepted input words and result words
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_word(op_t'(op), int'(pos_x), int'(pos_y), int'(heading),
                         int'(beam_angle), int'(range), int'(cell_col), int'(cell_row));
        if (out_valid && out_ready)
            sb.check_result(cell_state, in_grid);
    end

    // watchdog on cycles without any accepted word or taken result
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", sb.pending.size());
            $display("** occupancy_grid_ray_update: FAILED **");
            $finish;
        end
    end

    // result receiver: random stalls, always ready in no-idle mode, one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req) begin
            out_ready <= 0;
            repeat (400) @(negedge clk);
            hold_req = 0;
        end else if (no_idle) begin
            out_ready <= 1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    // ------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, int val);
        @(negedge clk);
        cfg_wr_en   <= 1;
        cfg_addr    <= idx;
        cfg_wr_data <= val[15:0];
        sb.set_reg(idx, val[15:0]);
        @(negedge clk);
        cfg_wr_en <= 0;
    endtask

    task automatic set_grid(int ox, int oy, int c, int r, int sh, int st, int h);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_COLS_USED, c);
        write_reg(REG_ROWS_USED, r);
        write_reg(REG_CELL_SHIFT, sh);
        write_reg(REG_STEP_LEN, st);
        write_reg(REG_FOOT_HALF, h);
    endtask

    // called at a falling edge; leaves the word on the port until accepted
    task automatic send_word(op_t o, int px, int py, int hd, int ba, int rng,
                             int col, int row);
        if (!no_idle && $urandom_range(0, 99) < 33) begin
            in_valid <= 0;
            do @(negedge clk); while ($urandom_range(0, 99) < 33);
        end
        in_valid   <= 1;
        op         <= o;
        pos_x      <= px[15:0];
        pos_y      <= py[15:0];
        heading    <= hd[11:0];
        beam_angle <= ba[11:0];
        range      <= rng[15:0];
        cell_col   <= col[7:0];
        cell_row   <= row[7:0];
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // let all results drain, then the trailing cycles of a last word
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // random word placed mostly on or near the grid in use
    task automatic random_word(int max_range);
        int sel, span_x, span_y, px, py, rng, col, row;
        op_t o;
        sel    = $urandom_range(0, 99);
        o      = sel < 50 ? OP_BEAM : sel < 80 ? OP_READ : sel < 92 ? OP_FOOT : OP_NONE;
        span_x = (sb.cols > 256 ? 256 : sb.cols) << sb.shift;
        span_y = (sb.rows > 256 ? 256 : sb.rows) << sb.shift;
        if ($urandom_range(0, 9) == 0) begin
            px = $urandom_range(0, 65535);
            py = $urandom_range(0, 65535);
        end else begin
            px = sb.org_x + $urandom_range(0, span_x + 64) - 32;
            py = sb.org_y + $urandom_range(0, span_y + 64) - 32;
        end
        rng = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                           : $urandom_range(0, max_range);
        col = $urandom_range(0, 255);
        row = $urandom_range(0, 255);
        if ($urandom_range(0, 1) == 0 && sb.cols <= 256) col = $urandom_range(0, sb.cols - 1);
        if ($urandom_range(0, 1) == 0 && sb.rows <= 256) row = $urandom_range(0, sb.rows - 1);
        send_word(o, px, py, $urandom_range(0, 4095), $urandom_range(0, 4095), rng, col, row);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed words at reset placement
        send_word(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_READ, 0, 0, 0, 0, 0, 255, 255);
        send_word(OP_BEAM, 1024, 1024, 0, 0, 200, 0, 0);
        send_word(OP_READ, 0, 0, 0, 0, 0, 64, 64);
        send_word(OP_BEAM, 2048, 2048, 4095, 4095, 0, 0, 0);
        send_word(OP_BEAM, 2048, 2048, 1024, 2048, 700, 0, 0);
        send_word(OP_BEAM, -32768, -32768, 512, 0, 300, 0, 0);
        send_word(OP_BEAM, -15, -15, 0, 0, 0, 0, 0);
        send_word(OP_BEAM, 32767, 32767, 2048, 1024, 65535, 0, 0);
        send_word(OP_BEAM, 100, 3000, 3072, 0, 65535, 0, 0);
        send_word(OP_FOOT, 2048, 2048, 0, 0, 0, 0, 0);
        send_word(OP_FOOT, -32768, 32767, 0, 0, 0, 0, 0);
        send_word(OP_READ, 0, 0, 0, 0, 0, 128, 128);
        send_word(OP_NONE, -1, -1, 4095, 4095, 65535, 255, 255);
        send_word(OP_READ, 0, 0, 0, 0, 0, 8, 8);
        send_word(OP_BEAM, 2048, 2048, 2048, 2048, 65535, 170, 85);
        drain();

        // random at reset placement
        repeat (140) random_word(1500);
        drain();

        // single-cell grid, finest cells, unit steps, empty footprint
        set_grid(-32768, 32767, 1, 1, 0, 1, 0);
        send_word(OP_BEAM, -32768, 32767, 0, 0, 0, 0, 0);
        send_word(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_FOOT, -32768, 32767, 0, 0, 0, 0, 0);
        repeat (60) random_word(40);
        drain();

        // wide cells, longest step and footprint
        set_grid(-2048, -2048, 256, 200, 10, 255, 255);
        repeat (100) random_word(65535);
        drain();

        // odd placement, zero step (taken as one), oversized column count
        set_grid(100, -300, 37, 129, 5, 0, 12);
        repeat (40) random_word(400);
        drain();
        write_reg(REG_COLS_USED, 511);
        repeat (30) random_word(400);
        drain();

        // back to reset placement: hold-off while words keep coming
        set_grid(0, 0, 256, 256, 4, 8, 64);
        hold_req = 1;
        repeat (60) random_word(800);
        no_idle = 1;
        repeat (80) random_word(800);
        no_idle = 0;
        repeat (60) random_word(800);
        drain();

        $display("covered %0d words and %0d results over six grid placements",
                 sb.n_words, sb.n_results);
        $display("beam, footprint, read and unused words with receiver hold-off");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** occupancy_grid_ray_update: PASSED **");
        else
            $display("** occupancy_grid_ray_update: FAILED **");
        $finish;
    end

endmodule
